[design/dsm_pkg.sv]
`default_nettype none

package dsm_pkg;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_t;

  localparam logic [2:0] MODE_PUSH_ONE = 3'd0;
  localparam logic [2:0] MODE_POP_ONE  = 3'd1;
  localparam logic [2:0] MODE_PUSH_TWO = 3'd2;
  localparam logic [2:0] MODE_POP_TWO  = 3'd3;
  localparam logic [2:0] MODE_MERGE    = 3'd4;

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP_WAIT,
    S_MERGE
  } state_t;

endpackage

`default_nettype wire

[design/dsm_in_if.sv]
`default_nettype none

interface dsm_in_if #(
  parameter int WORD_BITS = 32
);
  logic                        valid;
  logic                        ready;
  logic [2:0]                  mode;
  logic signed [WORD_BITS-1:0] push_value;

  modport source (output valid, output mode, output push_value, input ready);
  modport sink   (input valid, input mode, input push_value, output ready);
endinterface

`default_nettype wire

[design/dsm_out_if.sv]
`default_nettype none

interface dsm_out_if #(
  parameter int WORD_BITS = 32,
  parameter int CNT_W     = 11
);
  logic                        valid;
  logic                        ready;
  logic [1:0]                  status;
  logic signed [WORD_BITS-1:0] pop_value;
  logic [CNT_W-1:0]            count_one;
  logic [CNT_W-1:0]            count_two;

  modport source (output valid, output status, output pop_value,
                  output count_one, output count_two, input ready);
  modport sink   (input valid, input status, input pop_value,
                  input count_one, input count_two, output ready);
endinterface

`default_nettype wire

[design/dsm_ram.sv]
`default_nettype none

module dsm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[design/dual_stack_with_merge.sv]
// Channel  Dir  Payload                                       Transaction
// in_ch    in   mode, push_value                              valid & ready
// out_ch   out  status, pop_value, count_one, count_two       valid & ready
//
// Push (also on overflow), pop and merge underflow, and unused modes: result registered in the cycle after accept.
// Pop: the word passes through the stack memory's registered read port and S_POP_WAIT into the result register.
// Merge of n words: store one is copied into store two, one word a cycle through store one's read port.
// One command in flight; a new one is taken as the previous result is taken.
// rst_n (sync) clears fill counts and control; stack memories are not cleared.
`default_nettype none

module dual_stack_with_merge #(
  parameter int STACK_DEPTH = 1024,
  parameter int WORD_BITS   = 32
) (
  input wire logic clk,
  input wire logic rst_n,
  dsm_in_if.sink   in_ch,
  dsm_out_if.source out_ch
);

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam logic [CW-1:0] FULL = CW'(STACK_DEPTH);

  dsm_pkg::state_t  state_r, state_nxt;
  logic [CW-1:0]    fill_one_r, fill_one_nxt;
  logic [CW-1:0]    fill_two_r, fill_two_nxt;
  logic [CW-1:0]    idx_r, idx_nxt;
  logic             rd_v_r, rd_v_nxt;
  logic             ovf_r, ovf_nxt;
  logic             sel_two_r, sel_two_nxt;
  logic             out_valid_r, out_valid_nxt;
  dsm_pkg::status_t out_status_r, out_status_nxt;
  logic [WORD_BITS-1:0] out_pop_r, out_pop_nxt;

  logic                 we_one, re_one, we_two, re_two;
  logic [AW-1:0]        waddr_one, raddr_one, waddr_two, raddr_two;
  logic [WORD_BITS-1:0] wdata_one, wdata_two, rdata_one, rdata_two;
  logic                 accept;

  dsm_ram #(.WIDTH(WORD_BITS), .DEPTH(STACK_DEPTH)) u_store_one (
    .clk   (clk),
    .we    (we_one),
    .waddr (waddr_one),
    .wdata (wdata_one),
    .re    (re_one),
    .raddr (raddr_one),
    .rdata (rdata_one)
  );

  dsm_ram #(.WIDTH(WORD_BITS), .DEPTH(STACK_DEPTH)) u_store_two (
    .clk   (clk),
    .we    (we_two),
    .waddr (waddr_two),
    .wdata (wdata_two),
    .re    (re_two),
    .raddr (raddr_two),
    .rdata (rdata_two)
  );

  assign in_ch.ready = (state_r == dsm_pkg::S_IDLE) && (!out_valid_r || out_ch.ready);
  assign accept      = in_ch.valid && in_ch.ready;

  assign out_ch.valid     = out_valid_r;
  assign out_ch.status    = out_status_r;
  assign out_ch.pop_value = out_pop_r;
  assign out_ch.count_one = fill_one_r;
  assign out_ch.count_two = fill_two_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dsm_pkg::S_IDLE;
      fill_one_r  <= '0;
      fill_two_r  <= '0;
      idx_r       <= '0;
      rd_v_r      <= 1'b0;
      ovf_r       <= 1'b0;
      sel_two_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_one_r  <= fill_one_nxt;
      fill_two_r  <= fill_two_nxt;
      idx_r       <= idx_nxt;
      rd_v_r      <= rd_v_nxt;
      ovf_r       <= ovf_nxt;
      sel_two_r   <= sel_two_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
    out_pop_r    <= out_pop_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    fill_one_nxt   = fill_one_r;
    fill_two_nxt   = fill_two_r;
    idx_nxt        = idx_r;
    rd_v_nxt       = rd_v_r;
    ovf_nxt        = ovf_r;
    sel_two_nxt    = sel_two_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_status_nxt = out_status_r;
    out_pop_nxt    = out_pop_r;
    we_one         = 1'b0;
    re_one         = 1'b0;
    we_two         = 1'b0;
    re_two         = 1'b0;
    waddr_one      = fill_one_r[AW-1:0];
    waddr_two      = fill_two_r[AW-1:0];
    raddr_one      = AW'(fill_one_r - CW'(1));
    raddr_two      = AW'(fill_two_r - CW'(1));
    wdata_one      = in_ch.push_value;
    wdata_two      = in_ch.push_value;

    unique case (state_r)
      dsm_pkg::S_IDLE: begin
        if (accept) begin
          out_pop_nxt = '0;
          unique case (in_ch.mode)
            dsm_pkg::MODE_PUSH_ONE: begin
              out_valid_nxt = 1'b1;
              if (fill_one_r == FULL) begin
                out_status_nxt = dsm_pkg::ST_OVERFLOW;
              end else begin
                we_one         = 1'b1;
                fill_one_nxt   = fill_one_r + CW'(1);
                out_status_nxt = dsm_pkg::ST_OK;
              end
            end
            dsm_pkg::MODE_PUSH_TWO: begin
              out_valid_nxt = 1'b1;
              if (fill_two_r == FULL) begin
                out_status_nxt = dsm_pkg::ST_OVERFLOW;
              end else begin
                we_two         = 1'b1;
                fill_two_nxt   = fill_two_r + CW'(1);
                out_status_nxt = dsm_pkg::ST_OK;
              end
            end
            dsm_pkg::MODE_POP_ONE: begin
              if (fill_one_r == '0) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = dsm_pkg::ST_UNDERFLOW;
              end else begin
                re_one       = 1'b1;
                fill_one_nxt = fill_one_r - CW'(1);
                sel_two_nxt  = 1'b0;
                state_nxt    = dsm_pkg::S_POP_WAIT;
              end
            end
            dsm_pkg::MODE_POP_TWO: begin
              if (fill_two_r == '0) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = dsm_pkg::ST_UNDERFLOW;
              end else begin
                re_two       = 1'b1;
                fill_two_nxt = fill_two_r - CW'(1);
                sel_two_nxt  = 1'b1;
                state_nxt    = dsm_pkg::S_POP_WAIT;
              end
            end
            dsm_pkg::MODE_MERGE: begin
              if (fill_one_r == '0) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = dsm_pkg::ST_UNDERFLOW;
              end else begin
                idx_nxt   = '0;
                rd_v_nxt  = 1'b0;
                ovf_nxt   = 1'b0;
                state_nxt = dsm_pkg::S_MERGE;
              end
            end
            default: begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = dsm_pkg::ST_OK;
            end
          endcase
        end
      end

      dsm_pkg::S_POP_WAIT: begin
        out_valid_nxt  = 1'b1;
        out_status_nxt = dsm_pkg::ST_OK;
        out_pop_nxt    = sel_two_r ? rdata_two : rdata_one;
        state_nxt      = dsm_pkg::S_IDLE;
      end

      dsm_pkg::S_MERGE: begin
        // read store one bottom first, write each word to store two in the cycle after its read
        raddr_one = idx_r[AW-1:0];
        wdata_two = rdata_one;
        if (idx_r < fill_one_r) begin
          re_one   = 1'b1;
          idx_nxt  = idx_r + CW'(1);
          rd_v_nxt = 1'b1;
        end else begin
          rd_v_nxt = 1'b0;
        end
        if (rd_v_r) begin
          if (fill_two_r == FULL) begin
            ovf_nxt = 1'b1;
          end else begin
            we_two       = 1'b1;
            fill_two_nxt = fill_two_r + CW'(1);
          end
        end
        if (!rd_v_r && (idx_r == fill_one_r)) begin
          fill_one_nxt   = '0;
          out_valid_nxt  = 1'b1;
          out_status_nxt = ovf_r ? dsm_pkg::ST_OVERFLOW : dsm_pkg::ST_OK;
          out_pop_nxt    = '0;
          state_nxt      = dsm_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = dsm_pkg::S_IDLE;
      end
    endcase
  end

  a_fill_one_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_one_r <= FULL)
    else $error("stack one fill beyond depth");

  a_fill_two_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_two_r <= FULL)
    else $error("stack two fill beyond depth");

  a_merge_no_shrink: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == dsm_pkg::S_MERGE |=> fill_two_r >= $past(fill_two_r))
    else $error("stack two shrank during merge");

  a_pop_one_dec: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_ch.mode == dsm_pkg::MODE_POP_ONE && fill_one_r != '0)
    |=> (fill_one_r + CW'(1) == $past(fill_one_r)) && state_r == dsm_pkg::S_POP_WAIT)
    else $error("pop on stack one did not decrement");

  a_fail_zero_pop: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != dsm_pkg::ST_OK) |-> out_pop_r == '0)
    else $error("nonzero pop value on failed transaction");

endmodule

`default_nettype wire
